### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LOC_ASSERT_IMPL(lbl, c, rn, ante, cons, msg) \
	lbl: assert property (@(posedge c) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LOC_ASSERT_NEXT(lbl, c, rn, ante, cons, msg) \
	lbl: assert property (@(posedge c) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/loc_pkg.sv
package loc_pkg;

	typedef struct packed {
		logic signed [19:0] obs_x;
		logic signed [19:0] obs_y;
		logic signed [19:0] obs_start_l;
		logic signed [19:0] obs_end_l;
		logic signed [15:0] obs_heading;
		logic signed [15:0] ego_yaw;
		logic signed [19:0] ego_l;
		logic               is_virtual;
		logic               is_static;
		logic               left_lane_present;
		logic               right_lane_present;
		logic               frame_end;
	} obs_t;

	typedef struct packed {
		logic       kind;
		logic [5:0] obstacle_index;
		logic [2:0] behavior_code;
		logic [2:0] position_code;
		logic       run_last;
	} res_t;

	typedef struct packed {
		logic        [9:0]  half_width;
		logic signed [15:0] opposite_yaw_limit;
		logic        [11:0] static_buffer;
		logic        [11:0] dynamic_buffer;
	} cfg_t;

	typedef enum logic [2:0] {
		CFG_HALF_WIDTH     = 3'd0,
		CFG_OPP_YAW_LIMIT  = 3'd1,
		CFG_STATIC_BUFFER  = 3'd2,
		CFG_DYNAMIC_BUFFER = 3'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BEH_UNCHANGED   = 3'd0,
		BEH_IGNORE      = 3'd1,
		BEH_LEFT_NUDGE  = 3'd2,
		BEH_RIGHT_NUDGE = 3'd3,
		BEH_FOLLOW      = 3'd4
	} beh_code_t;

	typedef enum logic [2:0] {
		POS_NONE        = 3'd0,
		POS_FRONT       = 3'd1,
		POS_FRONT_LEFT  = 3'd2,
		POS_REAR_LEFT   = 3'd3,
		POS_FRONT_RIGHT = 3'd4,
		POS_REAR_RIGHT  = 3'd5
	} pos_code_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_READ,
		ST_EMIT
	} state_t;

	localparam int NUM_ZONES = 4;

	localparam logic signed [19:0] ZONE_FRONT_LIM = 20'sd10240;
	localparam logic signed [19:0] ZONE_REAR_LIM  = -20'sd10240;
	localparam logic signed [19:0] ZONE_SIDE_LIM  = 20'sd1280;
	localparam logic signed [19:0] BEHIND_LIM     = -20'sd2560;

	localparam logic        [9:0]  CFG_HALF_WIDTH_RST = 10'd256;
	localparam logic signed [15:0] CFG_OPP_YAW_RST    = 16'sd0;
	localparam logic        [11:0] CFG_STATIC_RST     = 12'd128;
	localparam logic        [11:0] CFG_DYNAMIC_RST    = 12'd128;

	// zone order: front-left, rear-left, front-right, rear-right
	localparam logic signed [19:0] ZONE_RESET_X [NUM_ZONES] =
		'{ZONE_FRONT_LIM, ZONE_REAR_LIM, ZONE_FRONT_LIM, ZONE_REAR_LIM};
	localparam pos_code_t ZONE_POS [NUM_ZONES] =
		'{POS_FRONT_LEFT, POS_REAR_LEFT, POS_FRONT_RIGHT, POS_REAR_RIGHT};

endpackage

### hdl/lateral_obstacle_classifier_top.sv
// Behaviour result passes the input register and the result register; one obstacle per
// cycle unless stalled. On a frame-end obstacle the four zone indices are looked up
// in the follow-flag RAM, one read a cycle; its behaviour result is then loaded, and
// zone results follow one a cycle unless stalled; input waits until the last loads.
// Reset clears configuration to defaults, zones, counter and all handshake state.
// The follow-flag RAM is not cleared; each index is written before a zone can name it.
`include "assert_macros.svh"

module lateral_obstacle_classifier_top #(
	parameter int MAX_OBSTACLES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          obs_valid,
	output logic          obs_stall,
	input  loc_pkg::obs_t obs,
	output logic          res_valid,
	input  logic          res_stall,
	output loc_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import loc_pkg::*;

	localparam int CW = $clog2(MAX_OBSTACLES + 1);
	localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

	cfg_t cfg_q;

	logic   valid_s1;
	obs_t   item_s1;
	logic   consume;

	logic [CW-1:0] cnt_q;
	logic          tracked;
	beh_code_t     beh;

	logic signed [19:0] zx_q  [NUM_ZONES];
	logic [AW-1:0]      zi_q  [NUM_ZONES];
	logic [NUM_ZONES-1:0] zv_q;
	logic signed [19:0] zx_d  [NUM_ZONES];
	logic [AW-1:0]      zi_d  [NUM_ZONES];
	logic [NUM_ZONES-1:0] zv_d;

	logic [AW-1:0]        si_q [NUM_ZONES];
	logic [NUM_ZONES-1:0] sv_q;
	res_t                 pend_q;

	state_t               state_q, state_d;
	logic [2:0]           rd_cnt_q, rd_cnt_d;
	logic [NUM_ZONES-1:0] mask_q, mask_d;
	logic                 beh_done_q, beh_done_d;

	logic        ram_we;
	logic [AW-1:0] ram_raddr;
	logic [0:0]  ram_rdata;

	logic  res_valid_q;
	res_t  res_q;
	logic  out_ok;
	logic  res_load;
	res_t  res_d;
	res_t  beh_res;
	logic [1:0] z_sel;
	logic [NUM_ZONES-1:0] mask_rest;

	logic in_front, in_rear, left_ok, right_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width         <= CFG_HALF_WIDTH_RST;
			cfg_q.opposite_yaw_limit <= CFG_OPP_YAW_RST;
			cfg_q.static_buffer      <= CFG_STATIC_RST;
			cfg_q.dynamic_buffer     <= CFG_DYNAMIC_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HALF_WIDTH:     cfg_q.half_width         <= cfg_data[9:0];
				CFG_OPP_YAW_LIMIT:  cfg_q.opposite_yaw_limit <= cfg_data;
				CFG_STATIC_BUFFER:  cfg_q.static_buffer      <= cfg_data[11:0];
				CFG_DYNAMIC_BUFFER: cfg_q.dynamic_buffer     <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// input stage
	assign out_ok    = !res_valid_q || !res_stall;
	assign consume   = (state_q == ST_RUN) && valid_s1 && (item_s1.frame_end || out_ok);
	assign obs_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (obs_valid && !obs_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (obs_valid && !obs_stall) begin
			item_s1 <= obs;
		end
	end

	loc_decide u_decide (
		.item (item_s1),
		.cfg  (cfg_q),
		.beh  (beh)
	);

	assign tracked = cnt_q < CW'(MAX_OBSTACLES);

	// nearest obstacle per zone
	always_comb begin
		in_front = (item_s1.obs_x > 20'sd0) && (item_s1.obs_x < ZONE_FRONT_LIM);
		in_rear  = (item_s1.obs_x < 20'sd0) && (item_s1.obs_x > ZONE_REAR_LIM);
		left_ok  = item_s1.left_lane_present && (item_s1.obs_y > 20'sd0)
			&& (item_s1.obs_y < ZONE_SIDE_LIM);
		right_ok = item_s1.right_lane_present && (item_s1.obs_y < 20'sd0)
			&& (item_s1.obs_y > -ZONE_SIDE_LIM);
		for (int z = 0; z < NUM_ZONES; z++) begin
			logic hit;
			hit = 1'b0;
			if (z == 0 || z == 2) begin
				hit = in_front && (item_s1.obs_x < zx_q[z]);
			end else begin
				hit = in_rear && (item_s1.obs_x > zx_q[z]);
			end
			hit = hit && tracked && ((z < 2) ? left_ok : right_ok);
			zx_d[z] = hit ? item_s1.obs_x : zx_q[z];
			zi_d[z] = hit ? cnt_q[AW-1:0] : zi_q[z];
			zv_d[z] = hit | zv_q[z];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			zv_q  <= '0;
			sv_q  <= '0;
			for (int z = 0; z < NUM_ZONES; z++) begin
				zx_q[z] <= ZONE_RESET_X[z];
				zi_q[z] <= '0;
				si_q[z] <= '0;
			end
		end else if (consume) begin
			if (item_s1.frame_end) begin
				cnt_q <= '0;
				zv_q  <= '0;
				sv_q  <= zv_d;
				for (int z = 0; z < NUM_ZONES; z++) begin
					zx_q[z] <= ZONE_RESET_X[z];
					si_q[z] <= zi_d[z];
				end
			end else begin
				if (tracked) begin
					cnt_q <= cnt_q + 1'b1;
				end
				zv_q <= zv_d;
				for (int z = 0; z < NUM_ZONES; z++) begin
					zx_q[z] <= zx_d[z];
					zi_q[z] <= zi_d[z];
				end
			end
		end
	end

	assign beh_res = '{
		kind:           1'b0,
		obstacle_index: 6'(cnt_q),
		behavior_code:  beh,
		position_code:  (beh == BEH_FOLLOW) ? POS_FRONT : POS_NONE,
		run_last:       1'b1
	};

	always_ff @(posedge clk) begin
		if (consume && item_s1.frame_end) begin
			pend_q <= beh_res;
		end
	end

	// follow flags
	assign ram_we    = consume && tracked;
	assign ram_raddr = si_q[rd_cnt_q[1:0]];

	loc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_OBSTACLES)
	) u_follow_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (beh == BEH_FOLLOW),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			rd_cnt_q   <= '0;
			mask_q     <= '0;
			beh_done_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_cnt_q   <= rd_cnt_d;
			mask_q     <= mask_d;
			beh_done_q <= beh_done_d;
		end
	end

	always_comb begin
		z_sel = 2'd0;
		for (int z = NUM_ZONES - 1; z >= 0; z--) begin
			if (mask_q[z]) begin
				z_sel = 2'(z);
			end
		end
		mask_rest = mask_q & ~(4'b0001 << z_sel);
	end

	always_comb begin
		state_d    = state_q;
		rd_cnt_d   = rd_cnt_q;
		mask_d     = mask_q;
		beh_done_d = beh_done_q;
		res_load   = 1'b0;
		res_d      = beh_res;
		case (state_q)
			ST_RUN: begin
				if (consume) begin
					if (item_s1.frame_end) begin
						state_d    = ST_READ;
						rd_cnt_d   = '0;
						mask_d     = '0;
						beh_done_d = 1'b0;
					end else begin
						res_load = 1'b1;
					end
				end
			end
			ST_READ: begin
				rd_cnt_d = rd_cnt_q + 1'b1;
				if (rd_cnt_q != 3'd0) begin
					mask_d[rd_cnt_q[1:0] - 2'd1] =
						sv_q[rd_cnt_q[1:0] - 2'd1] & !ram_rdata[0];
				end
				if (rd_cnt_q == 3'(NUM_ZONES)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ok) begin
					res_load = 1'b1;
					if (!beh_done_q) begin
						beh_done_d     = 1'b1;
						res_d          = pend_q;
						res_d.run_last = (mask_q == '0);
						if (mask_q == '0) begin
							state_d = ST_RUN;
						end
					end else begin
						res_d = '{
							kind:           1'b1,
							obstacle_index: 6'(si_q[z_sel]),
							behavior_code:  BEH_UNCHANGED,
							position_code:  ZONE_POS[z_sel],
							run_last:       (mask_rest == '0)
						};
						mask_d = mask_rest;
						if (mask_rest == '0) begin
							state_d = ST_RUN;
						end
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_ok) begin
			res_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`LOC_ASSERT_IMPL(a_ram_wr_run, clk, arst_n, ram_we, state_q == ST_RUN,
		"follow flag written outside run state")
	`LOC_ASSERT_IMPL(a_mask_valid, clk, arst_n, state_q == ST_EMIT, (mask_q & ~sv_q) == '0,
		"zone result pending for an invalid zone")
	`LOC_ASSERT_NEXT(a_frame_drain, clk, arst_n, consume && item_s1.frame_end,
		state_q == ST_READ, "frame end did not start zone lookup")
	`LOC_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_OBSTACLES),
		"obstacle counter beyond capacity")

endmodule

### hdl/loc_ram.sv
module loc_ram #(
	parameter int WIDTH  = 1,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/loc_decide.sv
module loc_decide (
	input  loc_pkg::obs_t      item,
	input  loc_pkg::cfg_t      cfg,
	output loc_pkg::beh_code_t beh
);
	import loc_pkg::*;

	logic signed [15:0] yaw_err;
	logic signed [22:0] ego_w;
	logic signed [22:0] hw_w;
	logic signed [22:0] start_w;
	logic signed [22:0] end_w;
	logic signed [22:0] left_gap;
	logic signed [22:0] right_gap;
	logic signed [22:0] buf_w;
	logic signed [22:0] sb_w;
	logic               skip;

	always_comb begin
		yaw_err   = item.obs_heading - item.ego_yaw;
		ego_w     = 23'(item.ego_l);
		hw_w      = 23'({1'b0, cfg.half_width});
		start_w   = 23'(item.obs_start_l);
		end_w     = 23'(item.obs_end_l);
		left_gap  = ego_w - hw_w - end_w;
		right_gap = start_w - ego_w - hw_w;
		sb_w      = 23'({1'b0, cfg.static_buffer});
		buf_w     = item.is_static ? sb_w : 23'({1'b0, cfg.dynamic_buffer});

		skip = item.is_virtual
			|| (!item.is_static && (yaw_err < cfg.opposite_yaw_limit))
			|| (item.obs_x < BEHIND_LIM);

		if (skip) begin
			beh = BEH_UNCHANGED;
		end else if ((left_gap > buf_w) || (right_gap > buf_w)) begin
			beh = BEH_IGNORE;
		end else if ((ego_w - end_w) > sb_w) begin
			beh = BEH_LEFT_NUDGE;
		end else if ((start_w - ego_w) > sb_w) begin
			beh = BEH_RIGHT_NUDGE;
		end else begin
			beh = BEH_FOLLOW;
		end
	end

endmodule

### bench/tb_lateral_obstacle_classifier_top.sv
module tb_lateral_obstacle_classifier_top;
	timeunit 1ns;
	timeprecision 1ps;

	import loc_pkg::*;

	localparam int MAX_OBS = 64;
	localparam int ZONE_REACH = 10240;
	localparam int SIDE_REACH = 1280;
	localparam int BEHIND_REACH = -2560;
	localparam int NUM_CFG_REGS = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int OBS_W = $bits(obs_t);
	localparam pos_code_t ZONE_CODE [4] =
		'{POS_FRONT_LEFT, POS_REAR_LEFT, POS_FRONT_RIGHT, POS_REAR_RIGHT};

	logic clk;
	logic arst_n;
	logic obs_valid;
	logic obs_stall;
	obs_t obs;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	lateral_obstacle_classifier_top #(.MAX_OBSTACLES(MAX_OBS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.obs_valid(obs_valid),
		.obs_stall(obs_stall),
		.obs(obs),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	int half_w;
	logic signed [15:0] yaw_limit;
	int static_buf;
	int dynamic_buf;
	int zone_x [4];
	int zone_at [4];
	bit zone_ok [4];
	bit [MAX_OBS-1:0] follow_mark;
	int frame_count;
	res_t due_labels [$];

	int src_idle_pct;
	int sink_idle_pct;
	int hold_asked;
	int err_cnt;
	int obstacles_sent;
	int frames_closed;
	int labels_checked;
	int reg_writes;
	res_t want;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_frame();
		zone_x = '{ZONE_REACH, -ZONE_REACH, ZONE_REACH, -ZONE_REACH};
		zone_at = '{0, 0, 0, 0};
		zone_ok = '{0, 0, 0, 0};
		follow_mark = '0;
		frame_count = 0;
	endfunction

	function automatic void classify_obstacle(obs_t o);
		int x, y, sl, el, ego, gap_l, gap_r, buf_lim;
		logic signed [15:0] yaw_err;
		bit tracked, skip, fwd, aft, side_ok, x_ok;
		beh_code_t beh;
		res_t outs [$];
		res_t r;
		x = int'(o.obs_x);
		y = int'(o.obs_y);
		sl = int'(o.obs_start_l);
		el = int'(o.obs_end_l);
		ego = int'(o.ego_l);
		tracked = frame_count < MAX_OBS;
		if (tracked) begin
			fwd = x > 0 && x < ZONE_REACH;
			aft = x < 0 && x > -ZONE_REACH;
			for (int z = 0; z < 4; z++) begin
				side_ok = (z < 2) ? (o.left_lane_present && y > 0 && y < SIDE_REACH)
				                  : (o.right_lane_present && y < 0 && y > -SIDE_REACH);
				x_ok = (z % 2 == 0) ? (fwd && x < zone_x[z]) : (aft && x > zone_x[z]);
				if (side_ok && x_ok) begin
					zone_x[z] = x;
					zone_at[z] = frame_count;
					zone_ok[z] = 1'b1;
				end
			end
		end
		yaw_err = o.obs_heading - o.ego_yaw;
		skip = o.is_virtual;
		if (!skip && !o.is_static && yaw_err < yaw_limit)
			skip = 1'b1;
		if (!skip && x < BEHIND_REACH)
			skip = 1'b1;
		beh = BEH_UNCHANGED;
		if (!skip) begin
			gap_l = (ego - half_w) - el;
			gap_r = sl - (ego + half_w);
			buf_lim = o.is_static ? static_buf : dynamic_buf;
			if (gap_l > buf_lim || gap_r > buf_lim)
				beh = BEH_IGNORE;
			else if (ego - el > static_buf)
				beh = BEH_LEFT_NUDGE;
			else if (sl - ego > static_buf)
				beh = BEH_RIGHT_NUDGE;
			else
				beh = BEH_FOLLOW;
		end
		if (tracked)
			follow_mark[frame_count] = (beh == BEH_FOLLOW);
		r.kind = 1'b0;
		r.obstacle_index = 6'(frame_count);
		r.behavior_code = beh;
		r.position_code = (beh == BEH_FOLLOW) ? POS_FRONT : POS_NONE;
		r.run_last = 1'b0;
		outs.push_back(r);
		if (frame_count < MAX_OBS)
			frame_count++;
		if (o.frame_end) begin
			for (int z = 0; z < 4; z++) begin
				if (zone_ok[z] && !follow_mark[zone_at[z]]) begin
					r.kind = 1'b1;
					r.obstacle_index = 6'(zone_at[z]);
					r.behavior_code = BEH_UNCHANGED;
					r.position_code = ZONE_CODE[z];
					outs.push_back(r);
				end
			end
			clear_frame();
			frames_closed++;
		end
		outs[outs.size() - 1].run_last = 1'b1;
		foreach (outs[i])
			due_labels.push_back(outs[i]);
	endfunction

	task automatic send_obs(obs_t o);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			obs_valid <= 1'b0;
		end
		@(negedge clk);
		obs_valid <= 1'b1;
		obs <= o;
		do
			@(posedge clk);
		while (obs_stall);
		classify_obstacle(o);
		obstacles_sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_HALF_WIDTH: half_w = int'(data[9:0]);
			CFG_OPP_YAW_LIMIT: yaw_limit = data;
			CFG_STATIC_BUFFER: static_buf = int'(data[11:0]);
			CFG_DYNAMIC_BUFFER: dynamic_buf = int'(data[11:0]);
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all_regs(int hw, int lim, int sb, int db);
		write_reg(CFG_HALF_WIDTH, 16'(hw));
		write_reg(CFG_OPP_YAW_LIMIT, 16'(lim));
		write_reg(CFG_STATIC_BUFFER, 16'(sb));
		write_reg(CFG_DYNAMIC_BUFFER, 16'(db));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		obs_valid <= 1'b0;
		while (due_labels.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic obs_t base_obs(int x, int y, int sl, int el);
		obs_t o;
		o = '0;
		o.obs_x = 20'(x);
		o.obs_y = 20'(y);
		o.obs_start_l = 20'(sl);
		o.obs_end_l = 20'(el);
		o.is_static = 1'b1;
		o.left_lane_present = 1'b1;
		o.right_lane_present = 1'b1;
		return o;
	endfunction

	function automatic obs_t rand_obstacle(bit last);
		obs_t o;
		int ego, el;
		o = OBS_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		if ($urandom_range(99) < 88) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: o.obs_x = 20'($urandom_range(0, 20800) - 10400);
				6, 7: o.obs_x = 20'(BEHIND_REACH + $urandom_range(0, 6) - 3);
				8: o.obs_x = 20'(($urandom_range(1) ? ZONE_REACH : -ZONE_REACH)
				                 + $urandom_range(0, 4) - 2);
				default: ;
			endcase
			if ($urandom_range(9) < 7)
				o.obs_y = 20'($urandom_range(0, 2800) - 1400);
			if ($urandom_range(9) < 8) begin
				ego = $urandom_range(0, 4000) - 2000;
				el = ego + $urandom_range(0, 2400) - 1200;
				o.ego_l = 20'(ego);
				o.obs_end_l = 20'(el);
				o.obs_start_l = 20'(el - $urandom_range(0, 1600));
			end
			if ($urandom_range(1))
				o.obs_heading = 16'(o.ego_yaw + yaw_limit + $urandom_range(0, 4) - 2);
			o.is_virtual = ($urandom_range(9) == 0);
			o.frame_end = last;
		end
		return o;
	endfunction

	task automatic send_frames(int count);
		int sent, len, r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			len = (r < 88) ? $urandom_range(1, 12) :
			      (r < 97) ? $urandom_range(13, 40) : $urandom_range(60, 70);
			for (int i = 0; i < len; i++)
				send_obs(rand_obstacle(i == len - 1));
			sent += len;
		end
	endtask

	function automatic int pick_value(int lo, int hi, int dflt);
		case ($urandom_range(3))
			0: return lo;
			1: return hi;
			2: return dflt;
			default: return lo + int'($urandom_range(0, hi - lo));
		endcase
	endfunction

	task automatic test_directed();
		obs_t o;
		send_obs(base_obs(1000, 600, -700, -300));
		send_obs(base_obs(800, 600, 40, 500));
		send_obs(base_obs(-700, -400, 200, 600));
		send_obs(base_obs(-700, -900, 600, 900));
		o = base_obs(-100, 100, 0, 0);
		o.is_virtual = 1'b1;
		send_obs(o);
		// yaw error wraps to +1, kept
		o = base_obs(3000, -1279, -50, 50);
		o.is_static = 1'b0;
		o.obs_heading = -16'sd32768;
		o.ego_yaw = 16'sd32767;
		send_obs(o);
		// yaw error wraps to -1, skipped
		o.obs_heading = 16'sd32767;
		o.ego_yaw = -16'sd32768;
		send_obs(o);
		send_obs(base_obs(BEHIND_REACH - 1, 300, -50, 50));
		send_obs(base_obs(BEHIND_REACH, 300, -50, 50));
		send_obs(base_obs(ZONE_REACH, 1, 300, 700));
		send_obs(base_obs(100, SIDE_REACH, 300, 700));
		send_obs(base_obs(100, 0, 300, 700));
		o = base_obs(5000, 2000, -40, 40);
		o.frame_end = 1'b1;
		send_obs(o);
		o = base_obs(500, 300, -900, -600);
		o.left_lane_present = 1'b0;
		o.right_lane_present = 1'b0;
		send_obs(o);
		o = '0;
		o.obs_x = 20'h7FFFF;
		o.obs_y = 20'h7FFFF;
		o.obs_start_l = 20'h7FFFF;
		o.obs_end_l = 20'h7FFFF;
		o.ego_l = 20'h7FFFF;
		o.obs_heading = 16'h7FFF;
		o.ego_yaw = 16'h7FFF;
		o.is_virtual = 1'b0;
		o.is_static = 1'b1;
		o.left_lane_present = 1'b1;
		o.right_lane_present = 1'b1;
		o.frame_end = 1'b0;
		send_obs(o);
		o = '0;
		o.obs_x = 20'h80000;
		o.obs_y = 20'h80000;
		o.obs_start_l = 20'h80000;
		o.obs_end_l = 20'h80000;
		o.ego_l = 20'h80000;
		o.obs_heading = 16'h8000;
		o.ego_yaw = 16'h8000;
		send_obs(o);
		send_obs('1);
		o = '0;
		o.frame_end = 1'b1;
		send_obs(o);
		wait_drained();
	endtask

	task automatic test_register_settings();
		write_all_regs(0, -32768, 0, 0);
		for (int i = 0; i < 8; i++)
			send_obs(rand_obstacle(i == 7));
		wait_drained();
		write_all_regs(1023, 32767, 4095, 4095);
		for (int i = 0; i < 8; i++)
			send_obs(rand_obstacle(i == 7));
		wait_drained();
		write_all_regs(256, 0, 128, 128);
		// unmapped indexes must leave the settings alone
		for (int i = NUM_CFG_REGS; i < 8; i++)
			write_reg(3'(i), 16'hFFFF);
		for (int i = 0; i < 8; i++)
			send_obs(rand_obstacle(i == 7));
		wait_drained();
	endtask

	task automatic test_frame_overflow();
		obs_t o;
		for (int i = 0; i < MAX_OBS + 4; i++) begin
			o = rand_obstacle(1'b0);
			if (i == 5)
				o = base_obs(2000, 300, -50, 50);
			if (i == MAX_OBS + 1)
				o = base_obs(100, 300, 500, 900);
			o.frame_end = (i == MAX_OBS + 3);
			send_obs(o);
		end
		wait_drained();
	endtask

	task automatic test_output_holdoff();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_asked++;
		send_frames(40);
		wait_drained();
	endtask

	task automatic test_random_traffic(int src_pct, int sink_pct, int count);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		write_all_regs(pick_value(0, 1023, 256), pick_value(-32768, 32767, 0),
		               pick_value(0, 4095, 128), pick_value(0, 4095, 128));
		send_frames(count);
		wait_drained();
	endtask

	task automatic report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			err_cnt++;
			$display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// receiver: random stalls, plus one long hold-off per request
	initial begin
		int hold_left, hold_served;
		hold_left = 0;
		hold_served = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else
				res_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			labels_checked++;
			if (due_labels.size() == 0) begin
				err_cnt++;
				$display("%0t: expected no result, got %p", $time, res);
			end else begin
				want = due_labels.pop_front();
				report_field("kind", 8'(want.kind), 8'(res.kind));
				report_field("obstacle_index", 8'(want.obstacle_index),
				             8'(res.obstacle_index));
				report_field("behavior_code", 8'(want.behavior_code),
				             8'(res.behavior_code));
				report_field("position_code", 8'(want.position_code),
				             8'(res.position_code));
				report_field("run_last", 8'(want.run_last), 8'(res.run_last));
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((obs_valid && !obs_stall) || (res_valid && !res_stall) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		obs_valid = 1'b0;
		obs = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_asked = 0;
		err_cnt = 0;
		obstacles_sent = 0;
		frames_closed = 0;
		labels_checked = 0;
		reg_writes = 0;
		half_w = 256;
		yaw_limit = 16'sd0;
		static_buf = 128;
		dynamic_buf = 128;
		clear_frame();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_register_settings();
		test_frame_overflow();
		test_output_holdoff();
		test_random_traffic(20, 80, 90);
		test_random_traffic(80, 20, 90);
		test_random_traffic(0, 0, 90);

		if (due_labels.size() > 0) begin
			err_cnt++;
			$display("%0t: %0d results never arrived", $time, due_labels.size());
		end
		$display("%0d obstacles over %0d closed frames, %0d results checked, %0d register writes",
		         obstacles_sent, frames_closed, labels_checked, reg_writes);
		$display("covered corner cases, frame overflow, output hold-off and three idle mixes");
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
